[hdl/hma_pkg.sv]
// ----------------------------------------------------------------------------
// hma_pkg
// Shared types and constants for the monitor lock arbiter.
// ----------------------------------------------------------------------------
package hma_pkg;

    localparam int ID_W   = 8;
    localparam int CI_W   = 4;
    localparam int CFG_W  = 5;
    localparam int LIM_W  = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_ENTER  = 2'd0,
        OP_LEAVE  = 2'd1,
        OP_WAIT   = 2'd2,
        OP_SIGNAL = 2'd3
    } op_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } bk_state_t;

    typedef struct packed {
        op_t              op;
        logic [ID_W-1:0]  id;
        logic [CI_W-1:0]  ci;
        logic             bad_cond;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic             rejected;
        logic             last;
    } res_t;

endpackage

[hdl/hma_front.sv]
// ----------------------------------------------------------------------------
// hma_front
// Accepts requests, classifies them against the condition limit and holds
// them in a two-entry queue for the executor.
// ----------------------------------------------------------------------------
module hma_front #(
    parameter int MAX_CONDITIONS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  func,
    input  logic [hma_pkg::ID_W-1:0]    requester_id,
    input  logic [hma_pkg::CI_W-1:0]    cond_index,
    input  logic                        cfg_we,
    input  logic [hma_pkg::CFG_W-1:0]   cfg_wdata,
    output logic                        req_valid,
    input  logic                        req_take,
    output hma_pkg::req_t               req
);

    hma_pkg::req_t                  slot_reg [2];
    logic                           wr_ptr_reg;
    logic                           rd_ptr_reg;
    logic [1:0]                     cnt_reg;
    logic [hma_pkg::CFG_W-1:0]      cfg_reg;
    logic [hma_pkg::LIM_W-1:0]      limit;
    logic [hma_pkg::LIM_W-1:0]      cfg_ext;
    hma_pkg::req_t                  incoming;
    logic                           do_push;

    assign cfg_ext = hma_pkg::LIM_W'(cfg_reg);
    assign limit   = (cfg_ext < hma_pkg::LIM_W'(MAX_CONDITIONS)) ?
                     cfg_ext : hma_pkg::LIM_W'(MAX_CONDITIONS);

    always_comb
    begin
        incoming.op       = hma_pkg::op_t'(func);
        incoming.id       = requester_id;
        incoming.ci       = cond_index;
        incoming.bad_cond = hma_pkg::LIM_W'(cond_index) >= limit;
    end

    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full;
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            cfg_reg    <= hma_pkg::CFG_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (req_take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, req_take};
        end
    end

endmodule

[hdl/hma_back.sv]
// ----------------------------------------------------------------------------
// hma_back
// Executes one request in turn: read the queue heads as it is taken, then update
// state, write back the queue memories and emit up to two results.
// ----------------------------------------------------------------------------
module hma_back #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int MAX_CONDITIONS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_take,
    input  hma_pkg::req_t   req,
    input  logic            room2,
    output logic            push_a,
    output logic            push_b,
    output hma_pkg::res_t   res_a,
    output hma_pkg::res_t   res_b
);

    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int CIW  = (MAX_CONDITIONS > 1) ? $clog2(MAX_CONDITIONS) : 1;
    localparam int CMD  = (1 << CIW) << QW;

    hma_pkg::bk_state_t     state_reg, state_next;
    hma_pkg::req_t          cur_reg;

    logic [hma_pkg::ID_W-1:0] e_mem [QUEUE_DEPTH];
    logic [hma_pkg::ID_W-1:0] u_mem [QUEUE_DEPTH];
    logic [hma_pkg::ID_W-1:0] c_mem [CMD];
    logic [hma_pkg::ID_W-1:0] e_rd_reg, u_rd_reg, c_rd_reg;

    logic                   busy_reg, busy_next;
    logic [QW-1:0]          e_head_reg, e_head_next, u_head_reg, u_head_next;
    logic [CNTW-1:0]        e_cnt_reg, e_cnt_next, u_cnt_reg, u_cnt_next;
    logic [QW-1:0]          c_head_reg [MAX_CONDITIONS];
    logic [CNTW-1:0]        c_cnt_reg  [MAX_CONDITIONS];
    logic                   c_upd;
    logic [QW-1:0]          c_head_new;
    logic [CNTW-1:0]        c_cnt_new;

    logic                   e_wr, u_wr, c_wr;
    logic [QW-1:0]          e_wpos, u_wpos, c_wpos;
    logic [CIW-1:0]         cix, in_cix;
    logic [hma_pkg::ID_W-1:0] wid, ho_id;
    logic [hma_pkg::ID_W-1:0] rid;
    logic                   ho_any, ho_u, do_ho;
    logic [CNTW-1:0]        cc;
    logic [QW-1:0]          ch;

    function automatic logic [QW-1:0] inc_ptr(input logic [QW-1:0] h);
        return (h == QW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    function automatic logic [QW-1:0] tail_pos(input logic [QW-1:0] h,
                                                input logic [CNTW-1:0] c);
        logic [QW:0] s;
        s = (QW+1)'(h) + (QW+1)'(c);
        if (s >= (QW+1)'(QUEUE_DEPTH))
        begin
            s = s - (QW+1)'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    assign cix    = CIW'(cur_reg.ci);
    assign in_cix = CIW'(req.ci);
    assign wid    = cur_reg.id;
    assign rid    = wid;
    assign cc     = c_cnt_reg[cix];
    assign ch     = c_head_reg[cix];
    assign ho_u   = (u_cnt_reg != '0);
    assign ho_any = ho_u || (e_cnt_reg != '0);
    assign ho_id  = ho_u ? u_rd_reg : e_rd_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hma_pkg::BK_IDLE:
            begin
                if (req_valid && room2)
                begin
                    state_next = hma_pkg::BK_EXEC;
                end
            end
            hma_pkg::BK_EXEC: state_next = hma_pkg::BK_IDLE;
            default:          state_next = hma_pkg::BK_IDLE;
        endcase
    end

    // outputs and state update
    always_comb
    begin
        req_take    = (state_reg == hma_pkg::BK_IDLE) && req_valid && room2;
        push_a      = 1'b0;
        push_b      = 1'b0;
        res_a       = '{id: rid, rejected: 1'b1, last: 1'b1};
        res_b       = '{id: ho_id, rejected: 1'b0, last: 1'b1};
        busy_next   = busy_reg;
        e_head_next = e_head_reg;
        e_cnt_next  = e_cnt_reg;
        u_head_next = u_head_reg;
        u_cnt_next  = u_cnt_reg;
        c_upd       = 1'b0;
        c_head_new  = ch;
        c_cnt_new   = cc;
        e_wr        = 1'b0;
        u_wr        = 1'b0;
        c_wr        = 1'b0;
        e_wpos      = tail_pos(e_head_reg, e_cnt_reg);
        u_wpos      = tail_pos(u_head_reg, u_cnt_reg);
        c_wpos      = tail_pos(ch, cc);
        do_ho       = 1'b0;

        if (state_reg == hma_pkg::BK_EXEC)
        begin
            unique case (cur_reg.op)
                hma_pkg::OP_ENTER:
                begin
                    if (!busy_reg)
                    begin
                        busy_next = 1'b1;
                        push_a    = 1'b1;
                        res_a     = '{id: rid, rejected: 1'b0, last: 1'b1};
                    end
                    else if (e_cnt_reg == CNTW'(QUEUE_DEPTH))
                    begin
                        push_a = 1'b1;
                    end
                    else
                    begin
                        e_wr       = 1'b1;
                        e_cnt_next = e_cnt_reg + 1'b1;
                    end
                end
                hma_pkg::OP_LEAVE:
                begin
                    push_a = 1'b1;
                    res_a  = '{id: rid, rejected: 1'b0, last: !ho_any};
                    push_b = ho_any;
                    do_ho  = 1'b1;
                end
                hma_pkg::OP_WAIT:
                begin
                    if (cur_reg.bad_cond || cc == CNTW'(QUEUE_DEPTH))
                    begin
                        push_a = 1'b1;
                    end
                    else
                    begin
                        c_wr      = 1'b1;
                        c_upd     = 1'b1;
                        c_cnt_new = cc + 1'b1;
                        do_ho     = 1'b1;
                        push_a    = ho_any;
                        res_a     = '{id: ho_id, rejected: 1'b0, last: 1'b1};
                    end
                end
                hma_pkg::OP_SIGNAL:
                begin
                    push_a = 1'b1;
                    if (cur_reg.bad_cond)
                    begin
                        push_a = 1'b1;
                    end
                    else if (cc == '0)
                    begin
                        res_a = '{id: rid, rejected: 1'b0, last: 1'b1};
                    end
                    else if (u_cnt_reg != CNTW'(QUEUE_DEPTH))
                    begin
                        // release the condition head, park the signaller
                        res_a      = '{id: c_rd_reg, rejected: 1'b0, last: 1'b1};
                        c_upd      = 1'b1;
                        c_head_new = inc_ptr(ch);
                        c_cnt_new  = cc - 1'b1;
                        u_wr       = 1'b1;
                        u_cnt_next = u_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    push_a = 1'b0;
                end
            endcase

            // hand over: urgent queue first, then entry queue, else free
            if (do_ho)
            begin
                if (ho_u)
                begin
                    u_head_next = inc_ptr(u_head_reg);
                    u_cnt_next  = u_cnt_reg - 1'b1;
                end
                else if (e_cnt_reg != '0)
                begin
                    e_head_next = inc_ptr(e_head_reg);
                    e_cnt_next  = e_cnt_reg - 1'b1;
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cur_reg  <= req;
            e_rd_reg <= e_mem[e_head_reg];
            u_rd_reg <= u_mem[u_head_reg];
            c_rd_reg <= c_mem[{in_cix, c_head_reg[in_cix]}];
        end
        if (e_wr)
        begin
            e_mem[e_wpos] <= wid;
        end
        if (u_wr)
        begin
            u_mem[u_wpos] <= wid;
        end
        if (c_wr)
        begin
            c_mem[{cix, c_wpos}] <= wid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hma_pkg::BK_IDLE;
            busy_reg   <= 1'b0;
            e_head_reg <= '0;
            e_cnt_reg  <= '0;
            u_head_reg <= '0;
            u_cnt_reg  <= '0;
            for (int i = 0; i < MAX_CONDITIONS; i++)
            begin
                c_head_reg[i] <= '0;
                c_cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            e_head_reg <= e_head_next;
            e_cnt_reg  <= e_cnt_next;
            u_head_reg <= u_head_next;
            u_cnt_reg  <= u_cnt_next;
            if (c_upd)
            begin
                c_head_reg[cix] <= c_head_new;
                c_cnt_reg[cix]  <= c_cnt_new;
            end
        end
    end

endmodule

[hdl/hma_out_q.sv]
// ----------------------------------------------------------------------------
// hma_out_q
// Four-entry result queue; takes up to two results per cycle in order.
// ----------------------------------------------------------------------------
module hma_out_q (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_a,
    input  logic            push_b,
    input  hma_pkg::res_t   res_a,
    input  hma_pkg::res_t   res_b,
    output logic            room2,
    output logic            empty,
    input  logic            pop,
    output hma_pkg::res_t   head
);

    hma_pkg::res_t  q_reg [4];
    logic [1:0]     hd_reg, tl_reg;
    logic [2:0]     cnt_reg;
    logic           do_pop;
    logic [1:0]     tl_b;

    assign empty  = (cnt_reg == 3'd0);
    assign room2  = (cnt_reg <= 3'd2);
    assign do_pop = pop && !empty;
    assign head   = q_reg[hd_reg];
    assign tl_b   = tl_reg + 2'd1;

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            q_reg[tl_reg] <= res_a;
        end
        if (push_b)
        begin
            q_reg[tl_b] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hd_reg  <= 2'd0;
            tl_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            hd_reg  <= hd_reg + {1'b0, do_pop};
            tl_reg  <= tl_reg + {1'b0, push_a} + {1'b0, push_b};
            cnt_reg <= cnt_reg + {2'b0, push_a} + {2'b0, push_b} - {2'b0, do_pop};
        end
    end

endmodule

[hdl/hoare_monitor_arbiter_top.sv]
// ----------------------------------------------------------------------------
// hoare_monitor_arbiter_top
// Lock manager for a monitor with entry, urgent and condition queues.
// ----------------------------------------------------------------------------
// Input channel: present func, requester_id and cond_index with push; a
// request is taken at a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result sits on released_id,
// rejected and last; pop at a clock edge takes it. A request gives zero, one
// or two results, the final one marked by last.
// Configuration: cfg_we writes cfg_wdata into condition_count; write only
// while no request is in flight.
// Executor: a taken request is registered, then its results are written
// into the result queue; no new request is taken until the last one has
// done its queue memory read and write-back.
// Reset: all queues empty, monitor free, condition_count 16; no clearing
// pass is needed. A stalled result side fills the four-entry result queue,
// then the executor holds, then the two-entry request queue raises full.
// ----------------------------------------------------------------------------
module hoare_monitor_arbiter_top #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int MAX_CONDITIONS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  func,
    input  logic [hma_pkg::ID_W-1:0]    requester_id,
    input  logic [hma_pkg::CI_W-1:0]    cond_index,
    output logic                        empty,
    input  logic                        pop,
    output logic [hma_pkg::ID_W-1:0]    released_id,
    output logic                        rejected,
    output logic                        last,
    input  logic                        cfg_we,
    input  logic [hma_pkg::CFG_W-1:0]   cfg_wdata
);

    logic           req_valid, req_take, room2, push_a, push_b;
    hma_pkg::req_t  req;
    hma_pkg::res_t  res_a, res_b, head;

    hma_front #(.MAX_CONDITIONS(MAX_CONDITIONS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .requester_id (requester_id),
        .cond_index   (cond_index),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req_valid    (req_valid),
        .req_take     (req_take),
        .req          (req)
    );

    hma_back #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .MAX_CONDITIONS (MAX_CONDITIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req       (req),
        .room2     (room2),
        .push_a    (push_a),
        .push_b    (push_b),
        .res_a     (res_a),
        .res_b     (res_b)
    );

    hma_out_q u_out_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_a (push_a),
        .push_b (push_b),
        .res_a  (res_a),
        .res_b  (res_b),
        .room2  (room2),
        .empty  (empty),
        .pop    (pop),
        .head   (head)
    );

    assign released_id = head.id;
    assign rejected    = head.rejected;
    assign last        = head.last;

endmodule

[hdl/hma_checker.sv]
// ----------------------------------------------------------------------------
// hma_checker
// Port-level checks on the result channel of the monitor arbiter.
// ----------------------------------------------------------------------------
module hma_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [hma_pkg::ID_W-1:0]    released_id,
    input  logic                        rejected,
    input  logic                        last
);

    // a refusal always ends its request
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rejected |-> last)
        else $error("rejected result without last");

    // both results of a request are queued together
    a_pair_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !last |=> !empty)
        else $error("second result of request missing");

    // hold a waiting result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(released_id) && $stable(last))
        else $error("waiting result changed");

endmodule

bind hoare_monitor_arbiter_top hma_checker u_hma_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .released_id (released_id),
    .rejected    (rejected),
    .last        (last)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the monitor lock arbiter: random and directed
// requests, an in-bench monitor model predicts every released id.
// ----------------------------------------------------------------------------
class release_board;
    logic [9:0] pending[$];
    int         errors;

    // model state
    bit         busy;
    logic [7:0] entry_q[$];
    logic [7:0] urgent_q[$];
    logic [7:0] cond_q[16][$];
    logic [4:0] cond_limit;

    function void clear();
        busy = 0;
        entry_q.delete();
        urgent_q.delete();
        for (int i = 0; i < 16; i++) cond_q[i].delete();
        cond_limit = 5'd16;
        errors = 0;
    endfunction

    function void grant(logic [7:0] id, bit rej);
        pending.push_back({id, rej, 1'b0});
    endfunction

    function void hand_over();
        if (urgent_q.size() != 0) grant(urgent_q.pop_front(), 0);
        else if (entry_q.size() != 0) grant(entry_q.pop_front(), 0);
        else busy = 0;
    endfunction

    function void note_request(hma_pkg::op_t op, logic [7:0] id, logic [3:0] ci);
        int n0;
        n0 = pending.size();
        case (op)
            hma_pkg::OP_ENTER:
                if (!busy)
                begin
                    busy = 1;
                    grant(id, 0);
                end
                else if (entry_q.size() >= 16) grant(id, 1);
                else entry_q.push_back(id);
            hma_pkg::OP_LEAVE:
            begin
                grant(id, 0);
                hand_over();
            end
            default:
                if ({1'b0, ci} >= cond_limit) grant(id, 1);
                else if (op == hma_pkg::OP_WAIT)
                begin
                    if (cond_q[ci].size() >= 16) grant(id, 1);
                    else
                    begin
                        cond_q[ci].push_back(id);
                        hand_over();
                    end
                end
                else if (cond_q[ci].size() != 0)
                begin
                    if (urgent_q.size() >= 16) grant(id, 1);
                    else
                    begin
                        grant(cond_q[ci].pop_front(), 0);
                        urgent_q.push_back(id);
                    end
                end
                else grant(id, 0);
        endcase
        if (pending.size() > n0) pending[pending.size()-1][0] = 1'b1;
    endfunction

    function void check_release(logic [7:0] id, logic rej, logic lst);
        logic [9:0] exp_res;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10) $display("unexpected result id=%0d rej=%0d last=%0d", id, rej, lst);
            return;
        end
        exp_res = pending.pop_front();
        if (exp_res !== {id, rej, lst})
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp id=%0d rej=%0d last=%0d got id=%0d rej=%0d last=%0d",
                         exp_res[9:2], exp_res[1], exp_res[0], id, rej, lst);
        end
    endfunction
endclass

module tb;
    logic                      clk = 0;
    logic                      rst_n = 0;
    logic                      push = 0;
    logic                      full;
    logic [1:0]                func = 0;
    logic [hma_pkg::ID_W-1:0]  requester_id = 0;
    logic [hma_pkg::CI_W-1:0]  cond_index = 0;
    logic                      empty;
    logic                      pop = 0;
    logic [hma_pkg::ID_W-1:0]  released_id;
    logic                      rejected;
    logic                      last;
    logic                      cfg_we = 0;
    logic [hma_pkg::CFG_W-1:0] cfg_wdata = 0;

    release_board board;
    int  send_idle = 0;
    int  recv_stall = 0;
    int  quiet = 0;
    localparam int WATCHDOG = 5000;

    hoare_monitor_arbiter_top dut (.*);

    always #1 clk = ~clk;

    // receiver: random stall, check each popped result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty) board.check_release(released_id, rejected, last);
            pop <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty)) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG)
        begin
            $display("hoare_monitor_arbiter_top regression: fail");
            $finish;
        end
    end

    // push stays high between back-to-back requests; drop it only when idling
    task automatic send(hma_pkg::op_t op, logic [7:0] id, logic [3:0] ci);
        if ($urandom_range(99) < send_idle)
        begin
            push <= 0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle) @(posedge clk);
        end
        push <= 1;
        func <= op;
        requester_id <= id;
        cond_index <= ci;
        @(posedge clk);
        while (full) @(posedge clk);
        board.note_request(op, id, ci);
    endtask

    task automatic drain();
        push <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_limit(logic [4:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        board.cond_limit = v;
    endtask

    // well-formed traffic mostly: small cond indices, occasional noise
    task automatic random_phase(int n);
        hma_pkg::op_t op;
        logic [3:0] ci;
        for (int i = 0; i < n; i++)
        begin
            op = hma_pkg::op_t'($urandom_range(3));
            ci = ($urandom_range(9) < 8) ? 4'($urandom_range(3)) : 4'($urandom);
            send(op, 8'($urandom), ci);
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: enter, queueing, signal/wait paths, bad index, extremes
        send(hma_pkg::OP_LEAVE, 8'd0, 4'd0);
        send(hma_pkg::OP_ENTER, 8'hFF, 4'd15);
        send(hma_pkg::OP_ENTER, 8'd1, 4'd0);
        send(hma_pkg::OP_SIGNAL, 8'd2, 4'd0);
        send(hma_pkg::OP_WAIT, 8'hFF, 4'd0);
        send(hma_pkg::OP_SIGNAL, 8'd1, 4'd0);
        send(hma_pkg::OP_LEAVE, 8'd0, 4'd0);
        send(hma_pkg::OP_LEAVE, 8'hFF, 4'd0);
        send(hma_pkg::OP_WAIT, 8'hAA, 4'd15);
        set_limit(5'd1);
        send(hma_pkg::OP_WAIT, 8'h55, 4'd1);
        send(hma_pkg::OP_SIGNAL, 8'h55, 4'd15);
        set_limit(5'd0);
        send(hma_pkg::OP_WAIT, 8'd3, 4'd0);
        send(hma_pkg::OP_SIGNAL, 8'd3, 4'd0);
        set_limit(5'd31);
        // fill entry queue past full
        for (int i = 0; i < 18; i++) send(hma_pkg::OP_ENTER, 8'(i + 16), 4'd0);
        // fill a condition queue past full, then signal its waiters into the urgent queue
        for (int i = 0; i < 17; i++) send(hma_pkg::OP_WAIT, 8'(i + 64), 4'd5);
        for (int i = 0; i < 18; i++) send(hma_pkg::OP_SIGNAL, 8'(i + 128), 4'd5);
        for (int i = 0; i < 40; i++) send(hma_pkg::OP_LEAVE, 8'(i), 4'd0);

        set_limit(5'd16);
        random_phase(100);
        send_idle = 85;
        set_limit(5'd2);
        random_phase(100);
        send_idle = 0;
        recv_stall = 85;
        set_limit(5'd16);
        random_phase(100);
        send_idle = 27;
        recv_stall = 27;
        set_limit(5'd3);
        random_phase(100);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("hoare_monitor_arbiter_top regression: pass");
        else
            $display("hoare_monitor_arbiter_top regression: fail");
        $finish;
    end
endmodule
